/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; every macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lav_pkg.sv */
// shared constants and types for the look-at view matrix block
// no dependencies
package lav_pkg;

	localparam int COORD_W    = 32;   // input coordinate width
	localparam int ELEM_W     = 32;   // matrix element width
	localparam int NORM_MB    = 30;   // normalized magnitude width, msb at bit 29
	localparam int ROOT_STEPS = 32;   // one result bit of the square root per stage

	typedef logic [1:0] row_idx_t;

	localparam row_idx_t ROW_FIRST = 2'd0;
	localparam row_idx_t ROW_LAST  = 2'd3;

endpackage

/* src/look_at_view_matrix.sv */
// top level of the look-at view matrix block
// uses lav_pkg, lav_norm, lav_cross and lav_rows
//
// channel   dir  tdata fields (lsb first)                         side fields
// s_*       in   camera_x/y/z, aim_x/y/z, up_dir_x/y/z (32 each)  -
// m_*       out  row_index(2), elem0..elem3 (32 each), 6 pad      tlast=last_row, tuser=degenerate
//
// most stages from input transfer to first row (FRAC_BITS=16 gives Q16.16)
// sit in the two normalizers (32 square-root stages plus FRAC_BITS+1 divide stages each)
// each matrix leaves as four row transfers; the next matrix loads as its last row leaves
// the pipeline takes a new transfer every cycle while its last stage is free or draining
// a stall on m_tready freezes all stages together; nothing is dropped or repeated
// arst_n clears only valid bits and the row sequencer state
module look_at_view_matrix import lav_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // camera_x, camera_y, camera_z, aim_x, aim_y, aim_z,
	                                // up_dir_x, up_dir_y, up_dir_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // row_index, elem0, elem1, elem2, elem3, zero pad
	output logic         m_tlast,   // last_row
	output logic         m_tuser    // degenerate
);

	localparam int UW  = FRAC_BITS + 2;            // unit vector component width
	localparam int CW1 = UW + COORD_W + 1;         // cross(forward, up) width
	localparam int CW2 = 2 * UW + 1;               // cross(side, forward) width
	localparam int PSW = UW + COORD_W;             // unit times coordinate
	localparam int DSW = PSW + 2;                  // dot of unit vector and camera
	localparam int UDW = 2 * COORD_W + 2;          // dot of true up and camera
	localparam int RW  = (CW2 + 1 > UDW + 2) ? CW2 + 1 : UDW + 2;
	localparam int SB1 = 6 * COORD_W;
	localparam int SB2 = 3 * UW + 1 + 3 * COORD_W;
	localparam int SB3 = 6 * UW + 1 + 3 * COORD_W;

	// whole pipeline advances unless the last stage holds an item the sequencer cannot take
	logic en;
	logic rows_ready;

	// camera and aim vectors straight from the input transfer, and their difference
	logic [2:0][COORD_W-1:0] cam_in, aim_in;
	logic [2:0][COORD_W:0]   dir_in;

	assign cam_in = s_tdata[3*COORD_W-1:0];
	assign aim_in = s_tdata[6*COORD_W-1:3*COORD_W];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dir_in[i] = (COORD_W+1)'($signed(aim_in[i])) - (COORD_W+1)'($signed(cam_in[i]));
		end
	end

	// forward = normalize(aim - camera); up and camera ride along
	logic                v_n1;
	logic [2:0][UW-1:0]  fwd_n1;
	logic                z_n1;
	logic [SB1-1:0]      sb_n1;

	lav_norm #(.W(COORD_W + 1), .FB(FRAC_BITS), .SW(SB1)) u_norm_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_vec    (dir_in),
		.in_sb     ({s_tdata[9*COORD_W-1:6*COORD_W], s_tdata[3*COORD_W-1:0]}),
		.out_valid (v_n1),
		.out_vec   (fwd_n1),
		.out_zero  (z_n1),
		.out_sb    (sb_n1)
	);

	// low half of the side band is camera, high half is world up
	logic [2:0][COORD_W-1:0] up_n1, cam_n1;

	assign cam_n1 = sb_n1[3*COORD_W-1:0];
	assign up_n1  = sb_n1[6*COORD_W-1:3*COORD_W];

	// cross(forward, up) at full product precision
	logic                v_c1;
	logic [2:0][CW1-1:0] sc_c1;
	logic [SB2-1:0]      sb_c1;

	lav_cross #(.AW(UW), .BW(COORD_W), .SW(SB2)) u_cross_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_n1),
		.a         (fwd_n1),
		.b         (up_n1),
		.in_sb     ({fwd_n1, z_n1, cam_n1}),
		.out_valid (v_c1),
		.c         (sc_c1),
		.out_sb    (sb_c1)
	);

	// side = normalize(cross(forward, up))
	logic                v_n2;
	logic [2:0][UW-1:0]  side_n2;
	logic                z_n2;
	logic [SB2-1:0]      sb_n2;

	lav_norm #(.W(CW1), .FB(FRAC_BITS), .SW(SB2)) u_norm_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_c1),
		.in_vec    (sc_c1),
		.in_sb     (sb_c1),
		.out_valid (v_n2),
		.out_vec   (side_n2),
		.out_zero  (z_n2),
		.out_sb    (sb_n2)
	);

	logic [2:0][UW-1:0]      fwd_n2;
	logic                    z1_n2;
	logic [2:0][COORD_W-1:0] cam_n2;

	assign cam_n2 = sb_n2[3*COORD_W-1:0];
	assign z1_n2  = sb_n2[3*COORD_W];
	assign fwd_n2 = sb_n2[SB2-1:3*COORD_W+1];

	// true up = cross(side, forward), still at double fraction precision
	logic                v_c2;
	logic [2:0][CW2-1:0] tu_c2;
	logic [SB3-1:0]      sb_c2;

	lav_cross #(.AW(UW), .BW(UW), .SW(SB3)) u_cross_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_n2),
		.a         (side_n2),
		.b         (fwd_n2),
		.in_sb     ({side_n2, fwd_n2, z1_n2 | z_n2, cam_n2}),
		.out_valid (v_c2),
		.c         (tu_c2),
		.out_sb    (sb_c2)
	);

	logic [2:0][UW-1:0]      side_c2, fwd_c2;
	logic                    dg_c2;
	logic [2:0][COORD_W-1:0] cam_c2;

	assign cam_c2  = sb_c2[3*COORD_W-1:0];
	assign dg_c2   = sb_c2[3*COORD_W];
	assign fwd_c2  = sb_c2[3*COORD_W+3*UW:3*COORD_W+1];
	assign side_c2 = sb_c2[SB3-1:3*COORD_W+3*UW+1];

	// drop FRAC_BITS fraction bits, nearest with ties away from zero, then saturate
	function automatic logic [ELEM_W-1:0] round_sat(input logic signed [RW-1:0] v);
		logic [RW-1:0]     mag;
		logic [RW-1:0]     m;
		logic [ELEM_W-1:0] r;
		mag = v[RW-1] ? RW'(-v) : RW'(v);
		m   = (mag + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (v[RW-1])
			r = (m >= (RW'(1) << (ELEM_W - 1))) ? {1'b1, {(ELEM_W-1){1'b0}}} : -m[ELEM_W-1:0];
		else
			r = (m >= (RW'(1) << (ELEM_W - 1))) ? {1'b0, {(ELEM_W-1){1'b1}}} : m[ELEM_W-1:0];
		return r;
	endfunction

	// r1: round true up, side and forward products with camera
	logic                    v_r1;
	logic [2:0][ELEM_W-1:0]  tu_r1;
	logic signed [PSW-1:0]   sp_r1 [3];
	logic signed [PSW-1:0]   fp_r1 [3];
	logic [2:0][UW-1:0]      side_r1, fwd_r1;
	logic [2:0][COORD_W-1:0] cam_r1;
	logic                    dg_r1;

	// r2: true up products with camera, side and forward dot sums
	logic                    v_r2;
	logic signed [2*COORD_W-1:0] up_r2 [3];
	logic signed [DSW-1:0]   sd_r2, fd_r2;
	logic [2:0][ELEM_W-1:0]  tu_r2;
	logic [2:0][UW-1:0]      side_r2, fwd_r2;
	logic                    dg_r2;

	// r3: translation row rounded and saturated
	logic                    v_r3;
	logic [2:0][ELEM_W-1:0]  trans_r3;
	logic [2:0][ELEM_W-1:0]  tu_r3;
	logic [2:0][UW-1:0]      side_r3, fwd_r3;
	logic                    dg_r3;
	logic signed [UDW-1:0]   ud_c;

	assign ud_c = UDW'(up_r2[0]) + UDW'(up_r2[1]) + UDW'(up_r2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
			v_r3 <= 1'b0;
		end else if (en) begin
			v_r1 <= v_c2;
			v_r2 <= v_r1;
			v_r3 <= v_r2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tu_r1[i] <= round_sat(RW'($signed(tu_c2[i])));
				sp_r1[i] <= $signed(side_c2[i]) * $signed(cam_c2[i]);
				fp_r1[i] <= $signed(fwd_c2[i]) * $signed(cam_c2[i]);
			end
			side_r1 <= side_c2;
			fwd_r1  <= fwd_c2;
			cam_r1  <= cam_c2;
			dg_r1   <= dg_c2;

			for (int i = 0; i < 3; i++) begin
				up_r2[i] <= $signed(tu_r1[i]) * $signed(cam_r1[i]);
			end
			sd_r2   <= DSW'(sp_r1[0]) + DSW'(sp_r1[1]) + DSW'(sp_r1[2]);
			fd_r2   <= DSW'(fp_r1[0]) + DSW'(fp_r1[1]) + DSW'(fp_r1[2]);
			tu_r2   <= tu_r1;
			side_r2 <= side_r1;
			fwd_r2  <= fwd_r1;
			dg_r2   <= dg_r1;

			trans_r3[0] <= round_sat(-RW'(sd_r2));
			trans_r3[1] <= round_sat(-RW'(ud_c));
			trans_r3[2] <= round_sat(RW'(fd_r2));
			tu_r3   <= tu_r2;
			side_r3 <= side_r2;
			fwd_r3  <= fwd_r2;
			dg_r3   <= dg_r2;
		end
	end

	assign en       = !v_r3 || rows_ready;
	assign s_tready = en;

	// four row transfers per matrix
	lav_rows #(.FB(FRAC_BITS)) u_rows (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_r3),
		.in_ready (rows_ready),
		.side     (side_r3),
		.upv      (tu_r3),
		.fwd      (fwd_r3),
		.trans    (trans_r3),
		.degen    (dg_r3),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* src/lav_norm.sv */
// pipelined vector normalizer: magnitude scaling, sum of squares,
// bit-per-stage square root and bit-per-stage division; uses lav_pkg
module lav_norm import lav_pkg::*; #(
	parameter int W  = 33,
	parameter int FB = 16,
	parameter int SW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [2:0][W-1:0]          in_vec,
	input  logic [SW-1:0]              in_sb,
	output logic                       out_valid,
	output logic [2:0][FB+1:0]         out_vec,
	output logic                       out_zero,
	output logic [SW-1:0]              out_sb
);

	localparam int PW = $clog2(W + 1);
	localparam int MB = NORM_MB;
	localparam int NR = ROOT_STEPS;
	localparam int LW = MB + 1;
	localparam int QW = FB + 1;
	localparam int UW = FB + 2;
	localparam int DW = MB + FB + 1;

	// stage 1: magnitudes and largest magnitude
	logic [2:0][W-1:0] mag_c;
	logic [W-1:0]      mx_c;
	logic              v_s1;
	logic [2:0][W-1:0] m_s1;
	logic [2:0]        neg_s1;
	logic [W-1:0]      mx_s1;
	logic [SW-1:0]     sb_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][W-1] ? W'(-in_vec[i]) : in_vec[i];
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1  <= mag_c;
			mx_s1 <= mx_c;
			for (int i = 0; i < 3; i++) neg_s1[i] <= in_vec[i][W-1];
			sb_s1 <= in_sb;
		end
	end

	// stage 2: leading one position
	logic [PW-1:0]     pos_c;
	logic              v_s2;
	logic [2:0][W-1:0] m_s2;
	logic [2:0]        neg_s2;
	logic [PW-1:0]     pos_s2;
	logic              zero_s2;
	logic [SW-1:0]     sb_s2;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < W; b++) begin
			if (mx_s1[b]) pos_c = PW'(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2    <= m_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos_c;
			zero_s2 <= (mx_s1 == '0);
			sb_s2   <= sb_s1;
		end
	end

	// stage 3: common shift so the largest magnitude sits in [2^29, 2^30)
	logic [2:0][W+MB-1:0] sh_c;
	logic                 v_s3;
	logic [2:0][MB-1:0]   m_s3;
	logic [2:0]           neg_s3;
	logic                 zero_s3;
	logic [SW-1:0]        sb_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PW'(MB - 1))
				sh_c[i] = (W+MB)'(m_s2[i]) >> (pos_s2 - PW'(MB - 1));
			else
				sh_c[i] = (W+MB)'(m_s2[i]) << (PW'(MB - 1) - pos_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) m_s3[i] <= sh_c[i][MB-1:0];
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			sb_s3   <= sb_s2;
		end
	end

	// stage 4: squares
	logic                 v_s4;
	logic [2:0][2*MB-1:0] sq_s4;
	logic [2:0][MB-1:0]   m_s4;
	logic [2:0]           neg_s4;
	logic                 zero_s4;
	logic [SW-1:0]        sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s4[i] <= m_s3[i] * m_s3[i];
			m_s4    <= m_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			sb_s4   <= sb_s3;
		end
	end

	// stage 5 and root stages: index 0 holds the sum of squares
	logic                 rv     [NR+1];
	logic [63:0]          rn     [NR+1];
	logic [63:0]          rr     [NR+1];
	logic [2:0][MB-1:0]   rm     [NR+1];
	logic [2:0]           rneg   [NR+1];
	logic                 rzero  [NR+1];
	logic [SW-1:0]        rsb    [NR+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv[0] <= 1'b0;
		else if (en) rv[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn[0]    <= 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);
			rr[0]    <= '0;
			rm[0]    <= m_s4;
			rneg[0]  <= neg_s4;
			rzero[0] <= zero_s4;
			rsb[0]   <= sb_s4;
		end
	end

	for (genvar k = 0; k < NR; k++) begin : g_root
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [64:0] trial;

		assign trial = {1'b0, rr[k]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv[k+1] <= 1'b0;
			else if (en) rv[k+1] <= rv[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rn[k]} >= trial) begin
					rn[k+1] <= rn[k] - trial[63:0];
					rr[k+1] <= (rr[k] >> 1) + BIT;
				end else begin
					rn[k+1] <= rn[k];
					rr[k+1] <= rr[k] >> 1;
				end
				rm[k+1]    <= rm[k];
				rneg[k+1]  <= rneg[k];
				rzero[k+1] <= rzero[k];
				rsb[k+1]   <= rsb[k];
			end
		end
	end

	// division stages: index 0 holds the rounded dividends
	logic                 dv     [QW+1];
	logic [LW-1:0]        dlen   [QW+1];
	logic [2:0][DW-1:0]   drem   [QW+1];
	logic [2:0][QW-1:0]   dq     [QW+1];
	logic [2:0]           dneg   [QW+1];
	logic                 dzero  [QW+1];
	logic [SW-1:0]        dsb    [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv[0] <= 1'b0;
		else if (en) dv[0] <= rv[NR];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem[0][i] <= DW'({rm[NR][i], {FB{1'b0}}}) + DW'(rr[NR][LW-1:1]);
			end
			dlen[0]  <= rr[NR][LW-1:0];
			dq[0]    <= '0;
			dneg[0]  <= rneg[NR];
			dzero[0] <= rzero[NR];
			dsb[0]   <= rsb[NR];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int KK = FB - j;
		logic [DW:0] dl;

		assign dl = (DW+1)'(dlen[j]) << KK;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[j+1] <= 1'b0;
			else if (en) dv[j+1] <= dv[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if ({1'b0, drem[j][i]} >= dl) begin
						drem[j+1][i] <= drem[j][i] - dl[DW-1:0];
						dq[j+1][i]   <= dq[j][i] | (QW'(1) << KK);
					end else begin
						drem[j+1][i] <= drem[j][i];
						dq[j+1][i]   <= dq[j][i];
					end
				end
				dlen[j+1]  <= dlen[j];
				dneg[j+1]  <= dneg[j];
				dzero[j+1] <= dzero[j];
				dsb[j+1]   <= dsb[j];
			end
		end
	end

	// output stage: sign restored, zero vector forced to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dzero[QW])
					out_vec[i] <= '0;
				else if (dneg[QW][i])
					out_vec[i] <= UW'(-UW'(dq[QW][i]));
				else
					out_vec[i] <= UW'(dq[QW][i]);
			end
			out_zero <= dzero[QW];
			out_sb   <= dsb[QW];
		end
	end

endmodule

/* src/lav_cross.sv */
// two-stage cross product: registered products, then differences
// uses lav_pkg
module lav_cross import lav_pkg::*; #(
	parameter int AW = 18,
	parameter int BW = 32,
	parameter int SW = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [2:0][AW-1:0]      a,
	input  logic [2:0][BW-1:0]      b,
	input  logic [SW-1:0]           in_sb,
	output logic                    out_valid,
	output logic [2:0][AW+BW:0]     c,
	output logic [SW-1:0]           out_sb
);

	localparam int PRW = AW + BW;

	logic                  v_s1;
	logic signed [PRW-1:0] p_s1 [6];
	logic [SW-1:0]         sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= $signed(a[1]) * $signed(b[2]);
			p_s1[1] <= $signed(a[2]) * $signed(b[1]);
			p_s1[2] <= $signed(a[2]) * $signed(b[0]);
			p_s1[3] <= $signed(a[0]) * $signed(b[2]);
			p_s1[4] <= $signed(a[0]) * $signed(b[1]);
			p_s1[5] <= $signed(a[1]) * $signed(b[0]);
			sb_s1   <= in_sb;
			c[0]    <= (PRW+1)'(p_s1[0]) - (PRW+1)'(p_s1[1]);
			c[1]    <= (PRW+1)'(p_s1[2]) - (PRW+1)'(p_s1[3]);
			c[2]    <= (PRW+1)'(p_s1[4]) - (PRW+1)'(p_s1[5]);
			out_sb  <= sb_s1;
		end
	end

endmodule

/* src/lav_rows.sv */
// row sequencer: holds one finished matrix and sends it as four rows
// uses lav_pkg
module lav_rows import lav_pkg::*; #(
	parameter int FB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2:0][FB+1:0]     side,
	input  logic [2:0][ELEM_W-1:0] upv,
	input  logic [2:0][FB+1:0]     fwd,
	input  logic [2:0][ELEM_W-1:0] trans,
	input  logic                   degen,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [135:0]           m_tdata,
	output logic                   m_tlast,
	output logic                   m_tuser
);

	logic                   vld_q;
	row_idx_t               row_q;
	logic [2:0][FB+1:0]     side_q;
	logic [2:0][ELEM_W-1:0] upv_q;
	logic [2:0][FB+1:0]     fwd_q;
	logic [2:0][ELEM_W-1:0] trans_q;
	logic                   degen_q;
	logic                   load;
	logic [ELEM_W-1:0]      e0, e1, e2, e3;

	assign in_ready = !vld_q || (m_tready && row_q == ROW_LAST);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			row_q <= ROW_FIRST;
		end else if (load) begin
			vld_q <= 1'b1;
			row_q <= ROW_FIRST;
		end else if (vld_q && m_tready) begin
			if (row_q == ROW_LAST) vld_q <= 1'b0;
			row_q <= row_q + row_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			side_q  <= side;
			upv_q   <= upv;
			fwd_q   <= fwd;
			trans_q <= trans;
			degen_q <= degen;
		end
	end

	always_comb begin
		case (row_q)
			ROW_LAST: begin
				e0 = trans_q[0];
				e1 = trans_q[1];
				e2 = trans_q[2];
				e3 = ELEM_W'(1) << FB;
			end
			default: begin
				e0 = ELEM_W'($signed(side_q[row_q]));
				e1 = upv_q[row_q];
				e2 = ELEM_W'(-ELEM_W'($signed(fwd_q[row_q])));
				e3 = '0;
			end
		endcase
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {6'd0, e3, e2, e1, e0, row_q};
	assign m_tlast  = (row_q == ROW_LAST);
	assign m_tuser  = degen_q;

endmodule

/* src/lav_checker.sv */
// port-level checks on the row output of the look-at view matrix block
// uses assert_macros.svh; bound to look_at_view_matrix below
`include "assert_macros.svh"

module lav_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic         m_tlast
);

	// a stalled row holds still
	`ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "row changed under stall")

	// tlast marks exactly row three
	`ASSERT_NOW(a_last, m_tvalid, m_tlast == (m_tdata[1:0] == 2'd3), "tlast not on row three")

	// rows of one matrix follow without gaps and in order
	`ASSERT_NEXT(a_seq, m_tvalid && m_tready && !m_tlast,
		m_tvalid && (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1), "row sequence broken")

	// fourth column is zero on the rotation rows
	`ASSERT_NOW(a_col3, m_tvalid && !m_tlast, m_tdata[129:98] == 32'd0, "nonzero fourth column")

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);

/* test/tb_top.sv */
// self-checking testbench for the look-at view matrix block
// depends on lav_pkg and look_at_view_matrix; predicts all four rows per camera setup
module tb_top import lav_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB       = 16;
	localparam int N_RANDOM = 400;
	localparam int LAT      = 2 * FB + 87;

	typedef longint signed vec3_t [3];

	typedef struct packed {
		logic [31:0] up_z, up_y, up_x, aim_z, aim_y, aim_x, cam_z, cam_y, cam_x;
	} setup_t;

	typedef struct {
		row_idx_t    idx;
		logic [31:0] e0, e1, e2, e3;
		logic        last;
		logic        degen;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;    // camera_x/y/z, aim_x/y/z, up_dir_x/y/z
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;    // row_index, elem0..elem3, zero pad
	logic         m_tlast;    // last_row
	logic         m_tuser;    // degenerate

	setup_t pending_setups[$];
	row_t   expected_rows[$];
	setup_t cur_setup;
	int     mismatches;
	int     rows_seen;
	int     total_setups;
	bit     stall_done;

	look_at_view_matrix #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	// ---------------- arithmetic of the predictor ----------------

	function automatic longint unsigned magnitude(longint signed v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// unit vector in FB fraction bits; returns 1 on a zero-length input
	function automatic bit unit_vec(input vec3_t v, output vec3_t u);
		longint unsigned m[3];
		longint unsigned mx, len, q;
		for (int i = 0; i < 3; i++) m[i] = magnitude(v[i]);
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		if (mx == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
			return 1;
		end
		// bring the largest magnitude into [2^29, 2^30)
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FB) + (len >> 1)) / len;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 0;
	endfunction

	function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
		vec3_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	function automatic longint signed dot_prod(vec3_t a, vec3_t b);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	// drop FB fraction bits, ties away from zero, clamp to 32 bits signed
	function automatic logic [31:0] round_clamp(longint signed v);
		longint unsigned m;
		longint signed r;
		m = (magnitude(v) + (64'd1 << (FB - 1))) >> FB;
		if (m > 64'h8000_0000) m = 64'h8000_0000;
		r = v < 0 ? -longint'(m) : longint'(m);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		return r[31:0];
	endfunction

	// queues the four rows of the view matrix for one camera setup
	task automatic predict_matrix(setup_t st);
		vec3_t cam, aim, up, fwd, side_raw, side, tup, d;
		bit degen;
		row_t r;
		cam = '{longint'($signed(st.cam_x)), longint'($signed(st.cam_y)),
			longint'($signed(st.cam_z))};
		aim = '{longint'($signed(st.aim_x)), longint'($signed(st.aim_y)),
			longint'($signed(st.aim_z))};
		up  = '{longint'($signed(st.up_x)), longint'($signed(st.up_y)),
			longint'($signed(st.up_z))};
		for (int i = 0; i < 3; i++) d[i] = aim[i] - cam[i];
		degen = unit_vec(d, fwd);
		side_raw = cross_prod(fwd, up);
		if (unit_vec(side_raw, side)) degen = 1;
		tup = cross_prod(side, fwd);
		for (int i = 0; i < 3; i++) tup[i] = longint'($signed(round_clamp(tup[i])));
		for (int k = 0; k < 3; k++) begin
			r.idx   = row_idx_t'(k);
			r.e0    = side[k][31:0];
			r.e1    = tup[k][31:0];
			r.e2    = 32'(-fwd[k]);
			r.e3    = '0;
			r.last  = 1'b0;
			r.degen = degen;
			expected_rows.push_back(r);
		end
		r.idx   = ROW_LAST;
		r.e0    = round_clamp(-dot_prod(side, cam));
		r.e1    = round_clamp(-dot_prod(tup, cam));
		r.e2    = round_clamp(dot_prod(fwd, cam));
		r.e3    = 32'(1) << FB;
		r.last  = 1'b1;
		r.degen = degen;
		expected_rows.push_back(r);
	endtask

	// ---------------- stimulus ----------------

	function automatic setup_t make_setup(logic [31:0] cx, cy, cz, ax, ay, az,
		ux, uy, uz);
		setup_t st;
		st = '{up_z: uz, up_y: uy, up_x: ux, aim_z: az, aim_y: ay, aim_x: ax,
			cam_z: cz, cam_y: cy, cam_x: cx};
		return st;
	endfunction

	// mostly moderate coordinates so the matrix is meaningful, some full-range
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
			2: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
			default: return 32'($signed($urandom_range(0, 255)) - 128);
		endcase
	endfunction

	task automatic fill_stimulus();
		logic [31:0] one, mx, mn, a, b, c;
		one = 32'(1) << FB;
		mx  = 32'h7FFF_FFFF;
		mn  = 32'h8000_0000;
		// all zero: forward and side both degenerate
		pending_setups.push_back(make_setup(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// aim equal to camera
		pending_setups.push_back(make_setup(one, 2*one, 3*one, one, 2*one, 3*one, 0, one, 0));
		// typical camera
		pending_setups.push_back(make_setup(0, 0, 5*one, 0, 0, 0, 0, one, 0));
		pending_setups.push_back(make_setup(3*one, 4*one, -2*one, -one, one, 0, 0, one, 0));
		// up parallel to forward: side degenerate
		pending_setups.push_back(make_setup(0, 0, 0, 0, 7*one, 0, 0, one, 0));
		pending_setups.push_back(make_setup(0, 0, 0, 0, 0, one, 0, 0, -3*one));
		// zero up
		pending_setups.push_back(make_setup(one, 0, 0, 0, one, 0, 0, 0, 0));
		// extreme coordinates, translation saturates
		pending_setups.push_back(make_setup(mx, mx, mx, mn, mn, mn, 0, mx, 0));
		pending_setups.push_back(make_setup(mn, mn, mn, mx, mx, mx, mn, 0, mx));
		pending_setups.push_back(make_setup(mx, mn, mx, mn, mx, mn, mx, mn, mx));
		pending_setups.push_back(make_setup(mn, 0, mx, mx, 0, mn, mx, mx, mx));
		pending_setups.push_back(make_setup(mx, mx, mx, mx, mx, mx - 1, mn, mn, mn));
		// tiny differences and tiny up
		pending_setups.push_back(make_setup(0, 0, 0, 1, 0, 0, 0, 1, 0));
		pending_setups.push_back(make_setup(-1, -1, -1, 0, 0, 0, 1, -1, 1));
		pending_setups.push_back(make_setup(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		for (int i = 0; i < N_RANDOM; i++) begin
			a = rand_coord(); b = rand_coord(); c = rand_coord();
			case ($urandom_range(0, 9))
				0: pending_setups.push_back(make_setup($urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
				// aim on the camera now and then
				1: pending_setups.push_back(make_setup(a, b, c, a, b, c,
					rand_coord(), rand_coord(), rand_coord()));
				// up along the view direction now and then
				2: pending_setups.push_back(make_setup(0, 0, 0, a, b, c, a, b, c));
				default: pending_setups.push_back(make_setup(a, b, c,
					rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord()));
			endcase
		end
		total_setups = pending_setups.size();
	endtask

	// ---------------- clock, reset, run control ----------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		fill_stimulus();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// wait until every setup went in and every row came back
		wait (pending_setups.size() == 0 && !s_tvalid && expected_rows.size() == 0);
		repeat (LAT + 40) @(posedge clk);
		if (mismatches == 0 && expected_rows.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------- driver ----------------

	int src_gap;

	always @(posedge clk or negedge arst_n) begin
		bit          nxt_valid;
		logic [287:0] nxt_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  = 0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data  = s_tdata;
			if (s_tvalid && s_tready)
				predict_matrix(cur_setup);
			// slot is free once the current transfer is taken or nothing is offered
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					nxt_valid = 1'b0;
				end else if (pending_setups.size() > 0) begin
					cur_setup = pending_setups.pop_front();
					nxt_valid = 1'b1;
					nxt_data  = cur_setup;
					// idle bursts, none in the final stretch
					if (pending_setups.size() > 50 && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 11);
				end else begin
					nxt_valid = 1'b0;
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata  <= nxt_data;
		end
	end

	// ---------------- monitor and checker ----------------

	int sink_hold;

	always @(posedge clk or negedge arst_n) begin
		row_t exp_r;
		row_t got;
		bit   nxt_ready;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			sink_hold  = 0;
			stall_done = 0;
			rows_seen  = 0;
			mismatches = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.idx   = m_tdata[1:0];
				got.e0    = m_tdata[33:2];
				got.e1    = m_tdata[65:34];
				got.e2    = m_tdata[97:66];
				got.e3    = m_tdata[129:98];
				got.last  = m_tlast;
				got.degen = m_tuser;
				rows_seen++;
				if (expected_rows.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected row transfer: row %0d %h %h %h %h last %b deg %b",
							got.idx, got.e0, got.e1, got.e2, got.e3, got.last, got.degen);
				end else begin
					exp_r = expected_rows.pop_front();
					if (got.idx !== exp_r.idx || got.e0 !== exp_r.e0 || got.e1 !== exp_r.e1 ||
						got.e2 !== exp_r.e2 || got.e3 !== exp_r.e3 ||
						got.last !== exp_r.last || got.degen !== exp_r.degen) begin
						mismatches++;
						if (mismatches <= 10)
							$display("row mismatch: exp row %0d %h %h %h %h last %b deg %b, got row %0d %h %h %h %h last %b deg %b",
								exp_r.idx, exp_r.e0, exp_r.e1, exp_r.e2, exp_r.e3,
								exp_r.last, exp_r.degen, got.idx, got.e0, got.e1,
								got.e2, got.e3, got.last, got.degen);
					end
				end
			end
			// one long hold-off early on so the pipeline backs up into s_tready
			if (!stall_done && rows_seen >= 40) begin
				stall_done = 1;
				sink_hold  = 600;
			end
			if (sink_hold > 0) begin
				sink_hold--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
				if (rows_seen < 4 * (total_setups - 50) && $urandom_range(0, 7) == 0)
					sink_hold = $urandom_range(1, 11);
			end
			m_tready <= nxt_ready;
		end
	end

endmodule

/* look_at_view_matrix.f */
+incdir+src
src/lav_pkg.sv
src/lav_norm.sv
src/lav_cross.sv
src/lav_rows.sv
src/look_at_view_matrix.sv
src/lav_checker.sv
test/tb_top.sv
